>>> sv/bsc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Base64 stream codec package
// Shared group descriptor type and the alphabet mapping functions.
// ----------------------------------------------------------------------------
package bsc_pkg;

   localparam logic [7:0] PAD_CHAR = 8'h3d;
   localparam logic [7:0] CHAR_UPPER_A = 8'h41;
   localparam logic [7:0] CHAR_LOWER_A = 8'h61;
   localparam logic [7:0] CHAR_ZERO = 8'h30;
   localparam logic [7:0] CHAR_PLUS = 8'h2b;
   localparam logic [7:0] CHAR_SLASH = 8'h2f;

   // One completed group: up to four result words, oldest in slot 0.
   typedef struct packed {
      logic [3:0][7:0] chars;
      logic            four;
      logic            last;
   } bsc_group_type;

   // Six-bit value to base64 character.
   function automatic logic [7:0] enc_char(input logic [5:0] idx);
      logic [7:0] wide;
      wide = {2'b00, idx};
      priority if (idx < 6'd26) begin
         enc_char = CHAR_UPPER_A + wide;
      end else if (idx < 6'd52) begin
         enc_char = CHAR_LOWER_A + wide - 8'd26;
      end else if (idx < 6'd62) begin
         enc_char = CHAR_ZERO + wide - 8'd52;
      end else if (idx == 6'd62) begin
         enc_char = CHAR_PLUS;
      end else begin
         enc_char = CHAR_SLASH;
      end
   endfunction

   // Character to six-bit value; anything outside the alphabet gives zero.
   function automatic logic [5:0] dec_value(input logic [7:0] c);
      logic [7:0] v;
      v = 8'd0;
      if (c >= 8'h41 && c <= 8'h5a) begin
         v = c - CHAR_UPPER_A;
      end else if (c >= 8'h61 && c <= 8'h7a) begin
         v = c - CHAR_LOWER_A + 8'd26;
      end else if (c >= 8'h30 && c <= 8'h39) begin
         v = c - CHAR_ZERO + 8'd52;
      end else if (c == CHAR_PLUS) begin
         v = 8'd62;
      end else if (c == CHAR_SLASH) begin
         v = 8'd63;
      end
      dec_value = v[5:0];
   endfunction

endpackage
`default_nettype wire

>>> sv/bsc_req_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Base64 stream codec request channel
// Valid/ready channel carrying one input word.
// ----------------------------------------------------------------------------
interface bsc_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_in;
   logic       stream_last;

   modport source(output valid, output data_in, output stream_last, input ready);
   modport sink(input valid, input data_in, input stream_last, output ready);
endinterface
`default_nettype wire

>>> sv/bsc_rsp_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Base64 stream codec response channel
// Valid/ready channel carrying one result word.
// ----------------------------------------------------------------------------
interface bsc_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_out;
   logic       run_last;
   logic       stream_end;

   modport source(output valid, output data_out, output run_last, output stream_end,
                  input ready);
   modport sink(input valid, input data_out, input run_last, input stream_end,
                output ready);
endinterface
`default_nettype wire

>>> sv/bsc_accum.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Base64 group accumulator
// Collects input words into groups and converts a completed group.
// ----------------------------------------------------------------------------
module bsc_accum (
   input  wire logic                   clock,
   input  wire logic                   reset,
   bsc_req_if.sink                     req,
   input  wire logic                   csr_write_en,
   input  wire logic                   csr_write_data,
   output bsc_pkg::bsc_group_type      grp_data,
   output logic                        grp_valid,
   input  wire logic                   grp_ready
);

   logic                   mode_ff;
   logic [1:0]             count_ff;
   logic [1:0]             count_in;
   logic [23:0]            held_ff;
   logic [23:0]            held_in;
   logic                   grp_valid_ff;
   logic                   grp_valid_in;
   bsc_pkg::bsc_group_type grp_ff;
   bsc_pkg::bsc_group_type grp_in;

   logic [2:0]             n;
   logic [23:0]            held_sh;
   logic [23:0]            word;
   logic                   complete;
   logic                   accept;

   assign req.ready = !grp_valid_ff || grp_ready;
   assign accept    = req.valid && req.ready;

   always_comb begin
      n = {1'b0, count_ff} + 3'd1;
      grp_in = '0;
      grp_in.last = req.stream_last;
      if (mode_ff) begin
         held_sh  = {held_ff[17:0], bsc_pkg::dec_value(req.data_in)};
         complete = (n == 3'd4) || req.stream_last;
         unique case (n)
            3'd1:    word = held_sh << 18;
            3'd2:    word = held_sh << 12;
            3'd3:    word = held_sh << 6;
            default: word = held_sh;
         endcase
         grp_in.four     = 1'b0;
         grp_in.chars[0] = word[23:16];
         grp_in.chars[1] = word[15:8];
         grp_in.chars[2] = word[7:0];
         grp_in.chars[3] = 8'd0;
      end else begin
         held_sh  = {held_ff[15:0], req.data_in};
         complete = (n == 3'd3) || req.stream_last;
         unique case (n)
            3'd1:    word = held_sh << 16;
            3'd2:    word = held_sh << 8;
            default: word = held_sh;
         endcase
         grp_in.four = 1'b1;
         for (int i = 0; i < 4; i++) begin
            // Characters beyond the bytes present become padding.
            if (3'(i) > n) begin
               grp_in.chars[i] = bsc_pkg::PAD_CHAR;
            end else begin
               grp_in.chars[i] = bsc_pkg::enc_char(word[23 - 6 * i -: 6]);
            end
         end
      end

      count_in = count_ff;
      held_in  = held_ff;
      if (accept) begin
         if (complete) begin
            count_in = 2'd0;
            held_in  = 24'd0;
         end else begin
            count_in = n[1:0];
            held_in  = held_sh;
         end
      end

      grp_valid_in = grp_valid_ff && !grp_ready;
      if (accept && complete) begin
         grp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= 1'b0;
         count_ff     <= 2'd0;
         held_ff      <= 24'd0;
         grp_valid_ff <= 1'b0;
      end else if (csr_write_en) begin
         mode_ff      <= csr_write_data;
         count_ff     <= 2'd0;
         held_ff      <= 24'd0;
         grp_valid_ff <= grp_valid_in;
      end else begin
         count_ff     <= count_in;
         held_ff      <= held_in;
         grp_valid_ff <= grp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && complete) begin
         grp_ff <= grp_in;
      end
   end

   assign grp_data  = grp_ff;
   assign grp_valid = grp_valid_ff;

endmodule
`default_nettype wire

>>> sv/bsc_serial.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Base64 result serializer
// Sends the words of one completed group out one per handshake.
// ----------------------------------------------------------------------------
module bsc_serial (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire bsc_pkg::bsc_group_type grp_data,
   input  wire logic                   grp_valid,
   output logic                        grp_ready,
   bsc_rsp_if.source                   rsp
);

   bsc_pkg::bsc_group_type cur_ff;
   logic [1:0]             idx_ff;
   logic [1:0]             idx_in;
   logic                   valid_ff;
   logic                   valid_in;
   logic                   fire;
   logic                   is_last;
   logic                   load;

   assign is_last = cur_ff.four ? (idx_ff == 2'd3) : (idx_ff == 2'd2);
   assign fire    = valid_ff && rsp.ready;
   assign load    = !valid_ff || (fire && is_last);

   assign grp_ready      = load;
   assign rsp.valid      = valid_ff;
   assign rsp.data_out   = cur_ff.chars[idx_ff];
   assign rsp.run_last   = is_last;
   assign rsp.stream_end = is_last && cur_ff.last;

   always_comb begin
      valid_in = valid_ff;
      idx_in   = idx_ff;
      if (load) begin
         valid_in = grp_valid;
         idx_in   = 2'd0;
      end else if (fire) begin
         idx_in = idx_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         idx_ff   <= 2'd0;
      end else begin
         valid_ff <= valid_in;
         idx_ff   <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load && grp_valid) begin
         cur_ff <= grp_data;
      end
   end

endmodule
`default_nettype wire

>>> sv/base64_stream_codec_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Base64 stream codec core
// Streaming base64 encoder and decoder with the standard alphabet.
// ----------------------------------------------------------------------------
// In encode mode every request word is a raw byte; each third byte, or any byte
// marked stream_last, releases four base64 characters, a short final group
// being padded with '='. In decode mode every request word is a character
// ('=' and characters outside the alphabet count as zero); each fourth one,
// or one marked stream_last, releases three bytes, padding is not trimmed.
// A request word is taken whenever the group register in front of the
// serializer is free or being emptied, so words that do not close a group
// stream in at one per cycle while that holds. Results leave the serializer
// at one word per cycle while groups are waiting and the response side is
// ready. When encoding the serializer limits the sustained rate, as three
// bytes give four characters; when decoding the input side does, as four
// characters give three result words. The word that closes a group is
// converted into the group register as it is accepted; the serializer loads
// the group from there when it is done with its current one, then offers its
// first result from its own register. Writing csr_write_data selects the mode
// (1 decodes) and drops any partial group; write it only while the core is idle.
// ----------------------------------------------------------------------------
module base64_stream_codec_core (
   input  wire logic  clock,
   input  wire logic  reset,
   bsc_req_if.sink    req_chan,
   bsc_rsp_if.source  rsp_chan,
   input  wire logic  csr_write_en,
   input  wire logic  csr_write_data
);

   // Completed group handed from the accumulator to the serializer.
   bsc_pkg::bsc_group_type grp_data;
   logic                   grp_valid;
   logic                   grp_ready;

   // Accumulator: shifts each accepted word into the held bits and, when a
   // group closes, converts it to its result words in the same cycle.
   bsc_accum u_accum (
      .clock          (clock),
      .reset          (reset),
      .req            (req_chan),
      .csr_write_en   (csr_write_en),
      .csr_write_data (csr_write_data),
      .grp_data       (grp_data),
      .grp_valid      (grp_valid),
      .grp_ready      (grp_ready)
   );

   // Serializer: holds one group and presents its words in order, loading the
   // next group as the last word of the current one is taken.
   bsc_serial u_serial (
      .clock     (clock),
      .reset     (reset),
      .grp_data  (grp_data),
      .grp_valid (grp_valid),
      .grp_ready (grp_ready),
      .rsp       (rsp_chan)
   );

endmodule
`default_nettype wire

>>> sv/bsc_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Base64 stream codec port checker
// Watches the response port of the core over time.
// ----------------------------------------------------------------------------
module bsc_checker (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       rsp_valid,
   input wire logic       rsp_ready,
   input wire logic [7:0] rsp_data_out,
   input wire logic       rsp_run_last,
   input wire logic       rsp_stream_end
);

   // A stalled result word keeps its valid and its payload.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data_out)
         && $stable(rsp_run_last) && $stable(rsp_stream_end))
      else $error("result word changed while stalled");

   // The end of the stream always closes a run.
   a_end_closes_run: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stream_end |-> rsp_run_last)
      else $error("stream end without run end");

   // Nothing is offered right after reset.
   a_idle_after_reset: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result offered right after reset");

endmodule

bind base64_stream_codec_core bsc_checker u_bsc_checker (
   .clock          (clock),
   .reset          (reset),
   .rsp_valid      (rsp_chan.valid),
   .rsp_ready      (rsp_chan.ready),
   .rsp_data_out   (rsp_chan.data_out),
   .rsp_run_last   (rsp_chan.run_last),
   .rsp_stream_end (rsp_chan.stream_end)
);
`default_nettype wire
